/* rtl/core/box_average_downscale_defines.svh */
// Assertion macros shared by the box average downscaler RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef BOX_AVERAGE_DOWNSCALE_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALE_DEFINES_SVH

// expr must hold at every clock edge out of reset
`define BXA_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define BXA_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BXA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/bxavg_pkg.sv */
// Shared constants, types and register codes of the box average downscaler.
// No dependencies.
package bxavg_pkg;

	localparam int PIX_W       = 8;
	localparam int NUM_CH      = 3;
	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 4096;
	localparam int MAX_FACTOR  = 16;
	localparam int MIN_FACTOR  = 2;
	localparam int STORE_DEPTH = MAX_WIDTH / MIN_FACTOR;
	localparam int IDX_W       = $clog2(STORE_DEPTH);

	localparam int FW_W = 12;
	localparam int FH_W = 13;
	localparam int FF_W = 5;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int OFF_W = $clog2(MAX_FACTOR);

	// one block line, and the whole block
	localparam int ROW_SUM_W = PIX_W + OFF_W;
	localparam int SUM_W     = PIX_W + 2 * OFF_W;
	localparam int AREA_W    = 2 * OFF_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = FH_W;

	localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
	localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);
	localparam logic [FF_W-1:0] FACTOR_RESET = FF_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_SCALE_FACTOR = 2'd2
	} cfg_reg_t;

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [ROW_SUM_W-1:0] row_sum_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [AREA_W-1:0]    area_t;
	typedef logic [IDX_W-1:0]     idx_t;

	// per-pixel block position flags from the position sequencer
	typedef struct packed {
		logic start;     // first pixel of a block span on this line
		logic wr;        // last pixel of a block span: update line store
		logic first_row; // first line of the block
		logic last_row;  // last line of the block: emit result
		logic done;      // block is the last of the frame
		idx_t idx;       // output column
	} pos_t;

endpackage

/* rtl/core/bxavg_if.sv */
// Pixel stream channels of the box average downscaler: input and output.
// Depends on bxavg_pkg.
interface bxavg_in_if import bxavg_pkg::*; ();
	logic valid;
	logic ready;
	pix_t red_in;
	pix_t green_in;
	pix_t blue_in;

	modport source(output valid, red_in, green_in, blue_in, input ready);
	modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bxavg_out_if import bxavg_pkg::*; ();
	logic valid;
	logic ready;
	pix_t red_out;
	pix_t green_out;
	pix_t blue_out;
	logic frame_done;

	modport source(output valid, red_out, green_out, blue_out, frame_done, input ready);
	modport sink(input valid, red_out, green_out, blue_out, frame_done, output ready);
endinterface

/* rtl/core/box_average_downscale.sv */
// Box average downscaler top level: accumulate, line store update, divide.
// Depends on bxavg_pkg, bxavg_if, bxavg_ram, bxavg_ctrl and bxavg_div.
`include "box_average_downscale_defines.svh"

// Takes one RGB pixel per clock in raster order and emits one averaged pixel
// per F x F block, at the block's bottom-right pixel; frame_done marks the
// last block of the frame. Sustained rate is one pixel per cycle. A result
// reaches the output register once the pixel that completes its block has
// passed the registered line store read, the read-modify-write of the column
// sum and the eight-stage divider, in that order. The line
// store is a 1024 x 48 single-write, single-read RAM holding one column sum
// per output column; it is written on the first line of a block before it
// is read and needs no clearing after reset. Any output stall freezes the
// whole pipeline, input included. Writing any register restarts the frame;
// write registers only with the pipeline empty.
module box_average_downscale import bxavg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bxavg_in_if.sink              pix_in,
	bxavg_out_if.source           pix_out
);

	logic     advance;
	logic     accept;
	pos_t     pos;
	area_t    area;
	pix_t     px [NUM_CH];
	row_sum_t rs_next [NUM_CH];
	row_sum_t rs_q [NUM_CH];

	logic     valid_s1;
	logic     first_s1;
	logic     last_s1;
	logic     done_s1;
	idx_t     idx_s1;
	row_sum_t rs_s1 [NUM_CH];

	logic                    ram_re;
	logic                    ram_we;
	logic [NUM_CH*SUM_W-1:0] ram_rdata;
	logic [NUM_CH*SUM_W-1:0] ram_wdata;
	sum_t                    blk_sum [NUM_CH];

	pix_t avg [NUM_CH];
	logic avg_done;
	logic avg_valid;

	assign advance      = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = advance;
	assign accept       = pix_in.valid && advance;

	assign px[0] = pix_in.red_in;
	assign px[1] = pix_in.green_in;
	assign px[2] = pix_in.blue_in;

	bxavg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.pos       (pos),
		.area      (area)
	);

	// horizontal sum of the current block span on this line
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			rs_next[c] = pos.start ? ROW_SUM_W'(px[c]) : rs_q[c] + ROW_SUM_W'(px[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < NUM_CH; c++) begin
				rs_q[c] <= rs_next[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && pos.wr;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			first_s1 <= pos.first_row;
			last_s1  <= pos.last_row;
			done_s1  <= pos.done;
			idx_s1   <= pos.idx;
			for (int c = 0; c < NUM_CH; c++) begin
				rs_s1[c] <= rs_next[c];
			end
		end
	end

	// same column is revisited at least two pixels later, so no forwarding
	assign ram_re = accept && pos.wr;
	assign ram_we = valid_s1 && advance;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			blk_sum[c] = first_s1 ? SUM_W'(rs_s1[c])
				: ram_rdata[c*SUM_W +: SUM_W] + SUM_W'(rs_s1[c]);
			ram_wdata[c*SUM_W +: SUM_W] = blk_sum[c];
		end
	end

	bxavg_ram #(
		.DATA_W (NUM_CH * SUM_W),
		.DEPTH  (STORE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pos.idx),
		.rdata (ram_rdata)
	);

	bxavg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (valid_s1 && last_s1),
		.in_sum    (blk_sum),
		.in_done   (done_s1),
		.area      (area),
		.out_valid (avg_valid),
		.out_avg   (avg),
		.out_done  (avg_done)
	);

	assign pix_out.valid      = avg_valid;
	assign pix_out.red_out    = avg[0];
	assign pix_out.green_out  = avg[1];
	assign pix_out.blue_out   = avg[2];
	assign pix_out.frame_done = avg_done;

	`BXA_ASSERT_IMPLIES(a_no_rw_collision, ram_we && ram_re, idx_s1 != pos.idx,
		"line store read and write hit the same column")
	`BXA_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(idx_s1),
		"store update stage lost its transaction during a stall")

endmodule

/* rtl/core/bxavg_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bxavg_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/bxavg_ctrl.sv */
// Configuration registers and raster position sequencer of the downscaler.
// Depends on bxavg_pkg and box_average_downscale_defines.svh.
`include "box_average_downscale_defines.svh"

module bxavg_ctrl import bxavg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  step,
	output pos_t                  pos,
	output area_t                 area
);

	logic [FW_W-1:0]  width_q;
	logic [FH_W-1:0]  height_q;
	logic [FF_W-1:0]  factor_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [OFF_W-1:0] ox_q;
	logic [OFF_W-1:0] oy_q;
	idx_t             bc_q;

	logic [FW_W-1:0]   w_eff;
	logic [FH_W-1:0]   h_eff;
	logic [FF_W-1:0]   f_eff;
	logic [FF_W-1:0]   f_m1;
	logic [2*FF_W-1:0] f_sq;
	logic              col_end;
	logic              row_end;
	logic              ox_wrap;
	logic              oy_wrap;
	logic              last_bcol;
	logic              last_brow;
	logic              restart;

	// out-of-range settings are pinned to the nearest legal value
	assign w_eff = (width_q == '0) ? FW_W'(1) :
		(width_q > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q == '0) ? FH_W'(1) :
		(height_q > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : height_q;
	assign f_eff = (factor_q < FF_W'(MIN_FACTOR)) ? FF_W'(MIN_FACTOR) :
		(factor_q > FF_W'(MAX_FACTOR)) ? FF_W'(MAX_FACTOR) : factor_q;
	assign f_m1  = f_eff - FF_W'(1);
	assign f_sq  = f_eff * f_eff;
	assign area  = f_sq[AREA_W-1:0];

	assign col_end = (FW_W'(col_q) + FW_W'(1)) >= w_eff;
	assign row_end = (FH_W'(row_q) + FH_W'(1)) >= h_eff;
	assign ox_wrap = FF_W'(ox_q) == f_m1;
	assign oy_wrap = FF_W'(oy_q) == f_m1;

	// no whole block fits to the right of / below this one
	assign last_bcol = (FH_W'(col_q) + FH_W'(f_eff) + FH_W'(1)) > FH_W'(w_eff);
	assign last_brow = ((FH_W+1)'(row_q) + (FH_W+1)'(f_eff) + (FH_W+1)'(1))
		> (FH_W+1)'(h_eff);

	// a block span ending on a line always lies in a whole block column; spans in
	// the partial bottom rows only touch entries the next frame's first line rewrites
	always_comb begin
		pos.start     = ox_q == '0;
		pos.wr        = ox_wrap;
		pos.first_row = oy_q == '0;
		pos.last_row  = oy_wrap;
		pos.done      = last_bcol & last_brow;
		pos.idx       = bc_q;
	end

	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH,
				REG_FRAME_HEIGHT,
				REG_SCALE_FACTOR: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			factor_q <= FACTOR_RESET;
			col_q    <= '0;
			row_q    <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			bc_q     <= '0;
		end else if (restart) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[FH_W-1:0];
				REG_SCALE_FACTOR: factor_q <= cfg_data[FF_W-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
			bc_q  <= '0;
		end else if (step) begin
			if (col_end) begin
				col_q <= '0;
				ox_q  <= '0;
				bc_q  <= '0;
				if (row_end) begin
					row_q <= '0;
					oy_q  <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					oy_q  <= oy_wrap ? '0 : oy_q + OFF_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				ox_q  <= ox_wrap ? '0 : ox_q + OFF_W'(1);
				if (ox_wrap) begin
					bc_q <= bc_q + IDX_W'(1);
				end
			end
		end
	end

	`BXA_ASSERT_ALWAYS(a_ox_in_block, FF_W'(ox_q) < f_eff, "block x offset out of range")
	`BXA_ASSERT_ALWAYS(a_col_in_line, FW_W'(col_q) < w_eff, "column beyond frame width")
	`BXA_ASSERT_ALWAYS(a_row_in_frame, FH_W'(row_q) < h_eff, "row beyond frame height")

endmodule

/* rtl/core/bxavg_div.sv */
// Pipelined restoring divider: block sums divided by the block area,
// one quotient bit per stage for all channels. Depends on bxavg_pkg.
`include "box_average_downscale_defines.svh"

module bxavg_div import bxavg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  sum_t  in_sum [NUM_CH],
	input  logic  in_done,
	input  area_t area,
	output logic  out_valid,
	output pix_t  out_avg [NUM_CH],
	output logic  out_done
);

	logic valid_s [PIX_W];
	logic done_s  [PIX_W];
	sum_t rem_s   [PIX_W][NUM_CH];
	pix_t quo_s   [PIX_W][NUM_CH];

	sum_t rem_in  [PIX_W][NUM_CH];
	pix_t quo_in  [PIX_W][NUM_CH];
	sum_t rem_nx  [PIX_W][NUM_CH];
	pix_t quo_nx  [PIX_W][NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			rem_in[0][c] = in_sum[c];
			quo_in[0][c] = '0;
		end
		for (int s = 1; s < PIX_W; s++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				rem_in[s][c] = rem_s[s-1][c];
				quo_in[s][c] = quo_s[s-1][c];
			end
		end
	end

	// stage s settles quotient bit PIX_W-1-s; quotient fits since sum <= 255*area
	always_comb begin
		for (int s = 0; s < PIX_W; s++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (rem_in[s][c] >= (SUM_W'(area) << (PIX_W - 1 - s))) begin
					rem_nx[s][c] = rem_in[s][c] - (SUM_W'(area) << (PIX_W - 1 - s));
					quo_nx[s][c] = quo_in[s][c] | (PIX_W'(1) << (PIX_W - 1 - s));
				end else begin
					rem_nx[s][c] = rem_in[s][c];
					quo_nx[s][c] = quo_in[s][c];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < PIX_W; s++) begin
				valid_s[s] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int s = 1; s < PIX_W; s++) begin
				valid_s[s] <= valid_s[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			done_s[0] <= in_done;
			for (int s = 1; s < PIX_W; s++) begin
				done_s[s] <= done_s[s-1];
			end
			for (int s = 0; s < PIX_W; s++) begin
				for (int c = 0; c < NUM_CH; c++) begin
					rem_s[s][c] <= rem_nx[s][c];
					quo_s[s][c] <= quo_nx[s][c];
				end
			end
		end
	end

	assign out_valid = valid_s[PIX_W-1];
	assign out_done  = done_s[PIX_W-1];
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			out_avg[c] = quo_s[PIX_W-1][c];
		end
	end

	`BXA_ASSERT_IMPLIES(a_rem_below_area, out_valid,
		(rem_s[PIX_W-1][0] < SUM_W'(area)) && (rem_s[PIX_W-1][2] < SUM_W'(area)),
		"divider remainder not reduced below area")

endmodule

/* tb/bxavg_check.sv */
`timescale 1ns / 100ps
// Scoreboard for box_average_downscale: watches configuration writes and both
// pixel channels, predicts every averaged pixel and compares it field by field.
// Depends on bxavg_pkg and the bxavg_in_if / bxavg_out_if interfaces.
module bxavg_check import bxavg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bxavg_in_if                   pix_in,
	bxavg_out_if                  pix_out,
	output int                    mismatches,
	output int                    avgs_pending
);

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic frame_done;
	} avg_pix_t;

	logic [FW_W-1:0] width_reg;
	logic [FH_W-1:0] height_reg;
	logic [FF_W-1:0] factor_reg;

	int unsigned col_pos, row_pos, x_off, y_off;
	int unsigned line_sum [NUM_CH];
	int unsigned col_sum [STORE_DEPTH][NUM_CH];
	avg_pix_t    expected_avgs [$];
	int          errs = 0;
	int          pend_cnt = 0;

	assign mismatches   = errs;
	assign avgs_pending = pend_cnt;

	function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		x_off   = 0;
		y_off   = 0;
		for (int c = 0; c < NUM_CH; c++)
			line_sum[c] = 0;
	endfunction

	function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_FRAME_WIDTH:  width_reg  = d[FW_W-1:0];
			REG_FRAME_HEIGHT: height_reg = d[FH_W-1:0];
			REG_SCALE_FACTOR: factor_reg = d[FF_W-1:0];
			default: return;
		endcase
		restart_frame();
	endfunction

	function automatic void accumulate_pixel(pix_t r, pix_t g, pix_t b);
		int unsigned w, h, f, out_w, out_h, bcol, idx, area;
		int unsigned px [NUM_CH];
		avg_pix_t    avg;
		w     = clamp(width_reg, 1, MAX_WIDTH);
		h     = clamp(height_reg, 1, MAX_HEIGHT);
		f     = clamp(factor_reg, MIN_FACTOR, MAX_FACTOR);
		out_w = w / f;
		out_h = h / f;
		bcol  = col_pos / f;
		px[0] = r;
		px[1] = g;
		px[2] = b;
		for (int c = 0; c < NUM_CH; c++)
			line_sum[c] = (x_off == 0) ? px[c] : line_sum[c] + px[c];

		// partial blocks at the right and bottom edges never reach the store
		if (x_off == f - 1 && bcol < out_w && row_pos / f < out_h) begin
			idx = bcol % STORE_DEPTH;
			for (int c = 0; c < NUM_CH; c++)
				col_sum[idx][c] = (y_off == 0) ? line_sum[c] : col_sum[idx][c] + line_sum[c];
			if (y_off == f - 1) begin
				area = f * f;
				avg.red        = pix_t'(col_sum[idx][0] / area);
				avg.green      = pix_t'(col_sum[idx][1] / area);
				avg.blue       = pix_t'(col_sum[idx][2] / area);
				avg.frame_done = (bcol == out_w - 1) && (row_pos / f == out_h - 1);
				expected_avgs.push_back(avg);
			end
		end

		if (col_pos + 1 >= w) begin
			col_pos = 0;
			x_off   = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				y_off   = 0;
			end else begin
				row_pos++;
				y_off = (y_off + 1 >= f) ? 0 : y_off + 1;
			end
		end else begin
			col_pos++;
			x_off = (x_off + 1 >= f) ? 0 : x_off + 1;
		end
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			errs++;
		end
	endfunction

	function automatic void check_avg();
		avg_pix_t want;
		if (expected_avgs.size() == 0) begin
			$display("%0t ns: unexpected transaction, expected none, got r=%0d g=%0d b=%0d done=%0d",
				$time, pix_out.red_out, pix_out.green_out, pix_out.blue_out,
				pix_out.frame_done);
			errs++;
			return;
		end
		want = expected_avgs.pop_front();
		compare_field("red_out", want.red, pix_out.red_out);
		compare_field("green_out", want.green, pix_out.green_out);
		compare_field("blue_out", want.blue, pix_out.blue_out);
		compare_field("frame_done", want.frame_done, pix_out.frame_done);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			factor_reg = FACTOR_RESET;
			restart_frame();
			for (int i = 0; i < STORE_DEPTH; i++)
				for (int c = 0; c < NUM_CH; c++)
					col_sum[i][c] = 0;
			expected_avgs.delete();
		end else begin
			if (pix_out.valid && pix_out.ready)
				check_avg();
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			if (pix_in.valid && pix_in.ready)
				accumulate_pixel(pix_in.red_in, pix_in.green_in, pix_in.blue_in);
		end
		pend_cnt = expected_avgs.size();
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Top of the box_average_downscale testbench: clock, reset, register writes,
// pixel stimulus and output back-pressure; checking is done in bxavg_check.
// Depends on bxavg_pkg, the bxavg interfaces, the RTL and bxavg_check.
module tb;
	import bxavg_pkg::*;

	localparam int RAND_PIXELS  = 1850;
	localparam int IDLE_PCT     = 17;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 30;
	localparam int MAX_BURST    = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    avgs_pending;
	bit                    gaps_on = 1'b1;
	bit                    hold_req = 1'b0;
	int                    sent = 0;

	bxavg_in_if  pix_in ();
	bxavg_out_if pix_out ();

	box_average_downscale u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	bxavg_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pix_in       (pix_in),
		.pix_out      (pix_out),
		.mismatches   (mismatches),
		.avgs_pending (avgs_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// output side: random stalls, plus one long hold-off on request
	initial begin
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pix_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pix_out.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	function automatic pix_t rand_level();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return pix_t'($urandom_range(255));
	endfunction

	task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid    <= 1'b1;
		pix_in.red_in   <= r;
		pix_in.green_in <= g;
		pix_in.blue_in  <= b;
		do @(posedge clk); while (!pix_in.ready);
		sent++;
	endtask

	task automatic send_random(input int n, input bit mid_drain);
		for (int i = 0; i < n; i++) begin
			if (mid_drain && i == n / 2)
				drain_results();
			send_pixel(rand_level(), rand_level(), rand_level());
		end
	endtask

	// input goes quiet until every predicted pixel is out and the pipe is empty
	task automatic drain_results();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (avgs_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_frame(input int unsigned w, input int unsigned h,
		input int unsigned f, input bit [2:0] which);
		cfg_reg_t              regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs[0] = REG_FRAME_WIDTH;
		regs[1] = REG_FRAME_HEIGHT;
		regs[2] = REG_SCALE_FACTOR;
		vals[0] = CFG_DATA_W'(w);
		vals[1] = CFG_DATA_W'(h);
		vals[2] = CFG_DATA_W'(f);
		for (int i = 0; i < 3; i++) begin
			if (which[i]) begin
				cfg_we    <= 1'b1;
				cfg_index <= regs[i];
				cfg_data  <= vals[i];
				@(posedge clk);
			end
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned f_raw, f_eff, w, h, h_eff, kx, ky, n;
		bit [2:0]    which;
		bit          mid_drain;
		int          phase;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_FRAME_WIDTH;
		cfg_data        = '0;
		pix_in.valid    = 1'b0;
		pix_in.red_in   = '0;
		pix_in.green_in = '0;
		pix_in.blue_in  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 4x2 frame, F=2: full-scale and zero channels, rounding down
		program_frame(4, 2, 2, 3'b111);
		send_pixel(8'hFF, 8'h00, 8'h01);
		send_pixel(8'hFF, 8'h00, 8'h02);
		send_pixel(8'h00, 8'hFF, 8'h80);
		send_pixel(8'h00, 8'hFF, 8'h7F);
		send_pixel(8'hFF, 8'h00, 8'h03);
		send_pixel(8'hFF, 8'h00, 8'h04);
		send_pixel(8'h00, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'hFF, 8'h00);
		drain_results();

		// zero width/height/factor: frame smaller than one block, nothing out
		program_frame(0, 0, 0, 3'b111);
		send_random(3, 1'b0);
		drain_results();

		// factor below minimum, trailing partial column and row dropped
		program_frame(3, 3, 1, 3'b111);
		send_random(9, 1'b0);
		drain_results();

		// a register write in mid-frame starts a new frame
		program_frame(2, 2, 2, 3'b111);
		send_random(2, 1'b0);
		drain_results();
		program_frame(2, 2, 2, 3'b010);
		send_random(4, 1'b0);
		drain_results();

		phase = 0;
		while (sent < RAND_PIXELS) begin
			gaps_on = !(phase >= 3 && phase < 7);
			f_raw = $urandom_range(99);
			if (f_raw < 55)
				f_raw = 2;
			else if (f_raw < 75)
				f_raw = $urandom_range(3, 4);
			else if (f_raw < 85)
				f_raw = $urandom_range(5, 8);
			else if (f_raw < 92)
				f_raw = $urandom_range(9, 16);
			else if (f_raw < 96)
				f_raw = $urandom_range(0, 1);
			else
				f_raw = $urandom_range(17, 31);
			f_eff = (f_raw < MIN_FACTOR) ? MIN_FACTOR : (f_raw > MAX_FACTOR) ? MAX_FACTOR : f_raw;
			kx = (f_eff <= 4) ? $urandom_range(1, 4) : (f_eff <= 8) ? $urandom_range(1, 2) : 1;
			ky = (f_eff <= 4) ? $urandom_range(1, 4) : (f_eff <= 8) ? $urandom_range(1, 2) : 1;
			w = f_eff * kx + ($urandom_range(1) ? $urandom_range(0, f_eff - 1) : 0);
			h = f_eff * ky + ($urandom_range(1) ? $urandom_range(0, f_eff - 1) : 0);
			if ($urandom_range(99) < 5)
				w = $urandom_range(1, f_eff - 1);
			if ($urandom_range(99) < 5)
				h = $urandom_range(1, f_eff - 1);
			if ($urandom_range(99) < 4)
				h = $urandom_range(MAX_HEIGHT + 1, 8191);
			which = ($urandom_range(99) < 85) ? 3'b111 : 3'($urandom_range(1, 7));
			mid_drain = ($urandom_range(99) < 10);

			// long output hold-off: the pipe fills and the input must stall
			if (phase == 2) begin
				f_raw     = 2;
				w         = 8;
				h         = 8;
				which     = 3'b111;
				mid_drain = 1'b0;
			end

			h_eff = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
			n = $urandom_range(1, 2) * w * h_eff + $urandom_range(0, w);
			if (n > MAX_BURST)
				n = MAX_BURST;

			program_frame(w, h, f_raw, which);
			if (phase == 2)
				hold_req = 1'b1;
			send_random(n, mid_drain);
			drain_results();
			phase++;
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* box_average_downscale.f */
+incdir+rtl/core
rtl/core/bxavg_pkg.sv
rtl/core/bxavg_if.sv
rtl/core/bxavg_ram.sv
rtl/core/bxavg_ctrl.sv
rtl/core/bxavg_div.sv
rtl/core/box_average_downscale.sv
tb/bxavg_check.sv
tb/tb.sv
